/* src/pss_pkg.sv */
// pss_pkg: types and constants shared by the preorder subtree scan block.
// Holds the channel payload structs, the queue entry type and the item kind codes.
// No dependencies.
package pss_pkg;

   localparam int ID_WIDTH    = 32;
   localparam int LEN_WIDTH   = 21;
   localparam int DEPTH_WIDTH = 8;

   // Item kind, decided by the front end.
   localparam logic KIND_SCAN  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      logic                 start_req;
      logic [ID_WIDTH-1:0]  entity_id;
      logic [ID_WIDTH-1:0]  parent_id;
   } pss_req_type;

   typedef struct packed {
      logic                   in_subtree;
      logic                   scan_done;
      logic                   stack_overflow;
      logic [DEPTH_WIDTH-1:0] depth;
   } pss_rsp_type;

   typedef struct packed {
      logic                kind;
      logic [ID_WIDTH-1:0] entity_id;
      logic [ID_WIDTH-1:0] parent_id;
   } pss_entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic          valid;
      pss_entry_type entry;
   } pss_queue_type;

endpackage

/* src/pss_front.sv */
// pss_front: input acceptance, item classification and a two-entry queue.
// Depends on pss_pkg.
module pss_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pss_pkg::pss_req_type   req_data,
   output pss_pkg::pss_queue_type q_head,
   input  logic               q_pop
);
   import pss_pkg::*;

   localparam int QDEPTH = 2;
   localparam int QW     = $clog2(QDEPTH);
   localparam int CW     = $clog2(QDEPTH + 1);

   pss_entry_type         slot_ff [QDEPTH];
   logic [QW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;
   pss_entry_type         new_entry;

   assign req_stall = (cnt_ff == CW'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (cnt_ff != '0);

   always_comb begin
      new_entry.kind      = req_data.start_req ? KIND_START : KIND_SCAN;
      new_entry.entity_id = req_data.entity_id;
      new_entry.parent_id = req_data.parent_id;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign q_head.valid = (cnt_ff != '0);
   assign q_head.entry = slot_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(QDEPTH))
      else $error("queue count beyond depth");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

/* src/pss_back.sv */
// pss_back: ancestor stack engine; pops one ancestor per compare/fetch pair.
// Holds the stack memory, scan state and the result register. Depends on pss_pkg.
module pss_back #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pss_pkg::pss_queue_type        q_head,
   output logic                          q_pop,
   input  logic                          csr_write_enable,
   input  logic [pss_pkg::LEN_WIDTH-1:0] csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pss_pkg::pss_rsp_type          rsp_data
);
   import pss_pkg::*;

   localparam int IW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_COMPARE = 2'd1;
   localparam logic [1:0] ST_FETCH   = 2'd2;

   logic [ID_WIDTH-1:0]  stack_mem [STACK_DEPTH];
   logic [ID_WIDTH-1:0]  rd_data_ff;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 finished_ff, finished_in;
   logic [LEN_WIDTH-1:0] position_ff, position_in;
   logic [LEN_WIDTH-1:0] len_ff;
   logic [ID_WIDTH-1:0]  tos_ff, tos_in;
   logic [ID_WIDTH-1:0]  ent_ff, ent_in;
   logic [ID_WIDTH-1:0]  par_ff, par_in;
   logic [LEN_WIDTH-1:0] pos_ff, pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pss_rsp_type          rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 emit;
   logic                 member;
   logic                 ovf;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [ID_WIDTH-1:0]  wr_data;
   logic                 rd_en;
   logic [IW-1:0]        rd_addr;
   logic [CW-1:0]        count_less2;
   logic [LEN_WIDTH-1:0] pos_next;
   logic [LEN_WIDTH:0]   pos_plus1;
   logic [CW+7:0]        depth_wide;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pos_next    = position_ff + 1'b1;
   assign pos_plus1   = {1'b0, pos_ff} + 1'b1;
   assign count_less2 = count_ff - CW'(2);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      position_in = position_ff;
      tos_in      = tos_ff;
      ent_in      = ent_ff;
      par_in      = par_ff;
      pos_in      = pos_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      member      = 1'b0;
      ovf         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IW-1:0];
      wr_data     = ent_ff;
      rd_en       = 1'b0;
      rd_addr     = count_less2[IW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid && out_free) begin
               q_pop  = 1'b1;
               ent_in = q_head.entry.entity_id;
               par_in = q_head.entry.parent_id;
               priority if (q_head.entry.kind == KIND_START) begin
                  wr_en       = 1'b1;
                  wr_addr     = '0;
                  wr_data     = q_head.entry.entity_id;
                  tos_in      = q_head.entry.entity_id;
                  count_in    = CW'(1);
                  position_in = '0;
                  finished_in = (len_ff <= LEN_WIDTH'(1));
                  emit        = 1'b1;
                  member      = 1'b1;
               end else if (finished_ff) begin
                  emit = 1'b1;
               end else if (pos_next >= len_ff) begin
                  finished_in = 1'b1;
                  emit        = 1'b1;
               end else begin
                  pos_in   = pos_next;
                  state_in = ST_COMPARE;
               end
            end
         end
         ST_COMPARE: begin
            priority if (count_ff == '0) begin
               if (out_free) begin
                  finished_in = 1'b1;
                  emit        = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else if (tos_ff == par_ff) begin
               if (out_free) begin
                  if (count_ff >= CW'(STACK_DEPTH)) begin
                     ovf = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     tos_in   = ent_ff;
                     count_in = count_ff + 1'b1;
                  end
                  position_in = pos_ff;
                  finished_in = (pos_plus1 >= {1'b0, len_ff});
                  emit        = 1'b1;
                  member      = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               // Drop the top and fetch the one below it.
               count_in = count_ff - 1'b1;
               rd_en    = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            tos_in   = rd_data_ff;
            state_in = ST_COMPARE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      depth_wide                 = {8'b0, count_in};
      rsp_data_in.in_subtree     = member;
      rsp_data_in.scan_done      = finished_in;
      rsp_data_in.stack_overflow = ovf;
      rsp_data_in.depth          = depth_wide[7:0];
      rsp_valid_in               = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         finished_ff  <= 1'b1;
         position_ff  <= '0;
         len_ff       <= LEN_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      tos_ff <= tos_in;
      ent_ff <= ent_in;
      par_ff <= par_in;
      pos_ff <= pos_in;
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_busy_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE || state_ff == ST_FETCH) |-> !finished_ff)
      else $error("stack walk while no scan is active");

   a_fetch_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> count_ff == $past(count_ff) - 1'b1)
      else $error("fetch without a pop");

   a_live_member: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.scan_done) |-> rsp_data_ff.in_subtree)
      else $error("active scan reported a non-member");

endmodule

/* src/preorder_subtree_scan.sv */
// preorder_subtree_scan: top level of the subtree membership scanner.
// Joins the front end queue (pss_front) to the stack engine (pss_back); uses pss_pkg.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  pss_req_type (start_req, entity_id, parent_id)
//   rsp_     out        rsp_valid/rsp_stall  pss_rsp_type (in_subtree, scan_done,
//                                            stack_overflow, depth)
//   csr_     in         csr_write_enable     csr_write_data = array_length
//
// A start item, an item while no scan is active and an item past the array end are
// answered from the idle state of the stack engine. A scanning item moves on to the
// compare state and pops ancestors: each pop is a compare then a registered stack read.
// Reset is synchronous; the stack needs no clearing pass and the scan comes up done.
// A stalled result holds in the output register while the two-entry queue keeps
// taking transactions until it fills.
module preorder_subtree_scan #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pss_pkg::pss_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pss_pkg::pss_rsp_type          rsp_data,
   input  logic                          csr_write_enable,
   input  logic [pss_pkg::LEN_WIDTH-1:0] csr_write_data
);
   import pss_pkg::*;

   // Queue head handed from the front end to the stack engine.
   pss_queue_type q_head;
   logic          q_pop;

   // Accept and classify transactions; hold them until the engine is free.
   pss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   // Walk the ancestor stack and produce one result per transaction.
   pss_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

/* test/pss_scan_checker.sv */
// pss_scan_checker: watches the request, response and CSR ports of the preorder subtree scan
// block, predicts every response and compares it field by field. Depends on pss_pkg.
module pss_scan_checker #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  pss_pkg::pss_req_type          req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  pss_pkg::pss_rsp_type          rsp_data,
   input  logic                          csr_write_enable,
   input  logic [pss_pkg::LEN_WIDTH-1:0] csr_write_data,
   output int                            mismatch_count,
   output int                            pending_count
);
   import pss_pkg::*;

   localparam int PRINT_LIMIT = 100;

   logic [ID_WIDTH-1:0]  ancestor_ids [STACK_DEPTH];
   int                   anc_count;
   logic [LEN_WIDTH-1:0] scan_pos;
   logic                 scan_finished;
   logic [LEN_WIDTH-1:0] array_len;
   pss_rsp_type          membership_q [$];
   int                   rsp_seen;

   // Advance the shadow ancestor stack by one request and return its response.
   function automatic pss_rsp_type membership_of(input pss_req_type item);
      pss_rsp_type          r;
      logic [LEN_WIDTH-1:0] next_pos;
      r = '0;
      if (item.start_req == KIND_START) begin
         ancestor_ids[0] = item.entity_id;
         anc_count       = 1;
         scan_pos        = '0;
         scan_finished   = (array_len <= 1);
         r.in_subtree    = 1'b1;
      end else if (!scan_finished) begin
         next_pos = scan_pos + 1'b1;
         if (next_pos >= array_len) begin
            scan_finished = 1'b1;
         end else begin
            while (anc_count > 0 && ancestor_ids[anc_count-1] != item.parent_id)
               anc_count--;
            if (anc_count == 0) begin
               scan_finished = 1'b1;
            end else begin
               if (anc_count >= STACK_DEPTH) begin
                  r.stack_overflow = 1'b1;
               end else begin
                  ancestor_ids[anc_count] = item.entity_id;
                  anc_count++;
               end
               scan_pos = next_pos;
               if (int'(next_pos) + 1 >= int'(array_len)) scan_finished = 1'b1;
               r.in_subtree = 1'b1;
            end
         end
      end
      r.scan_done = scan_finished;
      r.depth     = anc_count[DEPTH_WIDTH-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch on response %0d, %s: got %0h, expected %0h",
                  rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pss_rsp_type want;
      if (reset) begin
         anc_count      = 0;
         scan_pos       = '0;
         scan_finished  = 1'b1;
         array_len      = 1;
         rsp_seen       = 0;
         mismatch_count = 0;
         membership_q.delete();
      end else begin
         if (csr_write_enable) array_len = csr_write_data;
         // responses first, so one arriving with nothing queued is never masked
         if (rsp_valid && !rsp_stall) begin
            if (membership_q.size() == 0) begin
               report_mismatch("response with none pending", 1, 0);
            end else begin
               want = membership_q.pop_front();
               if (rsp_data.in_subtree !== want.in_subtree)
                  report_mismatch("in_subtree", rsp_data.in_subtree, want.in_subtree);
               if (rsp_data.scan_done !== want.scan_done)
                  report_mismatch("scan_done", rsp_data.scan_done, want.scan_done);
               if (rsp_data.stack_overflow !== want.stack_overflow)
                  report_mismatch("stack_overflow", rsp_data.stack_overflow,
                                  want.stack_overflow);
               if (rsp_data.depth !== want.depth)
                  report_mismatch("depth", rsp_data.depth, want.depth);
            end
            rsp_seen++;
         end
         if (req_valid && !req_stall) membership_q.push_back(membership_of(req_data));
      end
      pending_count = membership_q.size();
   end

endmodule

/* test/tb_preorder_subtree_scan.sv */
// tb_preorder_subtree_scan: stimulus and verdict for the preorder subtree scan block.
// Drives pre-order entity arrays into the block; pss_scan_checker (with pss_pkg) does the checking.
module tb_preorder_subtree_scan;
   import pss_pkg::*;

   localparam int STACK_DEPTH = 128;
   localparam int QUIET_LIMIT = 4000;   // cycles with no transaction on either channel
   localparam int HOLD_CYCLES = 400;    // long receiver hold-off to fill the block
   localparam int DRAIN_TAIL  = 300;    // covers a full-stack pop sequence
   localparam int MAX_LEN     = 2097151;
   localparam int TOP_LEN     = 1048576;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   pss_req_type          req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   pss_rsp_type          rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [LEN_WIDTH-1:0] csr_write_data = '0;

   int mismatch_count;
   int pending_count;

   // idle percentages for each side, changed per phase
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // long hold-off handshake: main bumps hold_armed, receiver answers with hold_seen
   int hold_armed = 0;
   int hold_seen  = 0;
   int hold_left  = 0;

   int quiet_cycles = 0;

   // stimulus-side view of the array being generated: the current root-to-node path,
   // the array position and whether the scan is still live
   logic [ID_WIDTH-1:0] path_ids [$];
   int                  gen_pos  = 0;
   bit                  gen_live = 1'b0;
   int                  cur_len  = 1;
   int                  scan_items = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   preorder_subtree_scan #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   pss_scan_checker #(.STACK_DEPTH(STACK_DEPTH)) scan_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   // Receiver: stall at random, or hold stall high for a long stretch when armed.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_armed) begin
         hold_seen <= hold_armed;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic pss_req_type scan_req(input logic start, input logic [ID_WIDTH-1:0] ent,
                                            input logic [ID_WIDTH-1:0] par);
      pss_req_type it;
      it.start_req = start;
      it.entity_id = ent;
      it.parent_id = par;
      return it;
   endfunction

   // Open a new scan with a random root.
   function automatic pss_req_type root_item();
      pss_req_type it;
      it = scan_req(KIND_START, $urandom, $urandom);
      path_ids.delete();
      path_ids.push_back(it.entity_id);
      gen_pos  = 0;
      gen_live = (cur_len > 1);
      scan_items++;
      return it;
   endfunction

   // Well-formed child: climb up to 'pops' levels, then hang a fresh id under that node.
   function automatic pss_req_type child_item(input int pops);
      pss_req_type it;
      it = scan_req(KIND_SCAN, $urandom, path_ids[$]);
      scan_items++;
      // a length lowered under a live scan: this item lands past the array end
      if (gen_pos + 1 >= cur_len) begin
         gen_live = 1'b0;
         return it;
      end
      while (pops > 0 && path_ids.size() > 1) begin
         path_ids.delete(path_ids.size() - 1);
         pops--;
      end
      it.parent_id = path_ids[$];
      // mirror the dropped push on a full stack
      if (path_ids.size() < STACK_DEPTH) path_ids.push_back(it.entity_id);
      gen_pos++;
      if (gen_pos + 1 >= cur_len) gen_live = 1'b0;
      return it;
   endfunction

   // Offer one transaction, with a random gap first; return at the accepting edge.
   // Valid stays high when the next transaction follows without a gap.
   task automatic offer(input pss_req_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, wait for every pending response, then write the array length.
   task automatic set_length(input int len);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len[LEN_WIDTH-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_len = len;
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return 0;
      if (r < 16) return 1;
      if (r < 70) return $urandom_range(2, 24);
      if (r < 88) return $urandom_range(120, 200);
      if (r < 94) return TOP_LEN;
      return MAX_LEN;
   endfunction

   // One scan: mostly well-formed children, with the odd broken parent, restart, or
   // stray transaction at the end.
   task automatic run_scan(input bit resume, input bit deep);
      int n;
      int r;
      if (!(resume && gen_live)) offer(root_item());
      n = $urandom_range(2, deep ? 160 : 40);
      while (gen_live && n > 0) begin
         r = $urandom_range(99);
         if (r < 4) begin
            // parent that is not on the stack: the scan collapses
            offer(scan_req(KIND_SCAN, $urandom, $urandom));
            gen_live = 1'b0;
            scan_items++;
         end else if (r < 6) begin
            offer(root_item());
         end else begin
            offer(child_item(deep ? 0 : $urandom_range(0, 3)));
         end
         n--;
      end
      // stray transaction with a random parent: ignored when the scan is over,
      // otherwise it collapses a live scan
      if ($urandom_range(3) == 0) begin
         offer(scan_req(KIND_SCAN, $urandom, $urandom));
         gen_live = 1'b0;
         scan_items++;
      end
   endtask

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // no scan after reset: the transaction is ignored
      offer(scan_req(KIND_SCAN, '0, '0));
      // reset length of one: the root alone finishes the scan
      offer(scan_req(KIND_START, '1, '1));
      // length zero behaves as one
      set_length(0);
      offer(scan_req(KIND_START, '0, '0));
      offer(scan_req(KIND_SCAN, '1, '0));

      // small tree with extreme ids, a two-level climb, then a lost parent
      set_length(TOP_LEN);
      offer(scan_req(KIND_START, 32'hFFFF_FFFF, 32'h0000_0000));
      offer(scan_req(KIND_SCAN, 32'h0000_0000, 32'hFFFF_FFFF));
      offer(scan_req(KIND_SCAN, 32'hA5A5_A5A5, 32'h0000_0000));
      offer(scan_req(KIND_SCAN, 32'h5A5A_5A5A, 32'hFFFF_FFFF));
      offer(scan_req(KIND_SCAN, 32'h1234_5678, 32'h5A5A_5A5A));
      offer(scan_req(KIND_SCAN, 32'h0000_0001, 32'hDEAD_BEEF));
      offer(scan_req(KIND_SCAN, 32'h0000_0002, 32'hFFFF_FFFF));

      // lower the length under a live scan: next transaction is past the array end
      offer(scan_req(KIND_START, 32'h10, 32'h0));
      offer(scan_req(KIND_SCAN, 32'h11, 32'h10));
      offer(scan_req(KIND_SCAN, 32'h12, 32'h11));
      set_length(2);
      offer(scan_req(KIND_SCAN, 32'h13, 32'h12));

      // exact array end: the last entity closes the scan, the next is ignored
      set_length(4);
      offer(scan_req(KIND_START, 32'h20, 32'h0));
      offer(scan_req(KIND_SCAN, 32'h21, 32'h20));
      offer(scan_req(KIND_SCAN, 32'h22, 32'h20));
      offer(scan_req(KIND_SCAN, 32'h23, 32'h22));
      offer(scan_req(KIND_SCAN, 32'h24, 32'h23));

      // deep chain past the stack depth: the last pushes overflow
      set_length(MAX_LEN);
      offer(root_item());
      repeat (STACK_DEPTH + 3) offer(child_item(0));

      // ---- random part, three idle profiles ----
      scan_items = 0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 35;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // hold the receiver off while the sender keeps pushing a live scan
               set_length(TOP_LEN);
               hold_armed++;
               offer(root_item());
               repeat (8) offer(child_item(0));
            end
         endcase
         while (scan_items < 360 * (phase + 1)) begin
            set_length(pick_length());
            repeat ($urandom_range(1, 4))
               run_scan($urandom_range(1), cur_len >= 120 && $urandom_range(2) == 0);
         end
      end

      // drain, then give the block time to show any stray response
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (DRAIN_TAIL) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
